// ----- design/doaq_pkg.sv -----
package doaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_FIRE    = 16;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int FIRE_W  = $clog2(MAX_FIRE + 1);
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int TAG_W   = 8;
  localparam int KIND_W  = 2;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_FIRED    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_inc;
    logic do_insert;
    logic do_reject;
    logic do_fire;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_tick;
    logic full;
    logic scan_stop;
    logic head_due;
    logic out_free;
  } stat_t;

endpackage

// ----- design/doaq_if.sv -----
interface doaq_req_if import doaq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [DELAY_W-1:0] delay_seconds;
  logic [TAG_W-1:0]   tag;

  modport source (output valid, output req_type, output delay_seconds, output tag,
                  input ready);
  modport sink (input valid, input req_type, input delay_seconds, input tag,
                output ready);
endinterface

interface doaq_rsp_if import doaq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TAG_W-1:0]   out_tag;
  logic [DELAY_W-1:0] out_delay;
  logic [TIME_W-1:0]  out_deadline;
  logic               last;

  modport source (output valid, output kind, output out_tag, output out_delay,
                  output out_deadline, output last, input ready);
  modport sink (input valid, input kind, input out_tag, input out_delay,
                input out_deadline, input last, output ready);
endinterface

// ----- design/deadline_ordered_alarm_queue.sv -----
// insert: scan to the final slot (pos, at most QUEUE_DEPTH - 1), then result; a full store rejects
// tick: n alarms fire (n at most MAX_FIRE), one result per cycle while out_rsp is ready
// the rate is set by the one-entry-per-cycle position scan and the one-pop-per-cycle fire loop
// one request at a time; a pending result does not block acceptance of the next request
// rst_n (synchronous, active low) clears the time counter, occupancy and result valid
// the entry store itself is not cleared; only entries below occupancy are read
module deadline_ordered_alarm_queue import doaq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  doaq_req_if.sink   in_req,
  doaq_rsp_if.source out_rsp
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;
  logic  ctrl_in_ready;

  // request side handshake comes from the sequencer only
  assign in_req.ready = ctrl_in_ready;

  // sequencer: idle, position scan, insert, reject, fire loop
  doaq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ctrl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: time counter, sorted shift store, result register
  doaq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (in_req.req_type),
    .in_delay    (in_req.delay_seconds),
    .in_tag      (in_req.tag),
    .out_rsp     (out_rsp)
  );

endmodule

// ----- design/doaq_ctrl.sv -----
module doaq_ctrl import doaq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_INS  = 5'b00100,
    S_REJ  = 5'b01000,
    S_FIRE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no request is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          if (stat.req_tick) begin
            state_nxt = S_FIRE;
          end else if (stat.full) begin
            state_nxt = S_REJ;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_stop) begin
          state_nxt = S_INS;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_INS: begin
        if (stat.out_free) begin
          cmd.do_insert = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.do_reject = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FIRE: begin
        if (!stat.head_due) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.do_fire = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/doaq_dp.sv -----
module doaq_dp import doaq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_req_type,
  input  logic [DELAY_W-1:0] in_delay,
  input  logic [TAG_W-1:0]   in_tag,
  doaq_rsp_if.source         out_rsp
);

  entry_t             entries_r [QUEUE_DEPTH];
  logic [TIME_W-1:0]  now_r;
  logic [CNT_W-1:0]   occ_r;
  logic [CNT_W-1:0]   ptr_r;
  logic [FIRE_W-1:0]  fire_cnt_r;
  logic [TIME_W-1:0]  dd_r;
  logic [DELAY_W-1:0] req_delay_r;
  logic [TAG_W-1:0]   req_tag_r;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [DELAY_W-1:0] out_delay_r;
  logic [TIME_W-1:0]  out_deadline_r;
  logic               out_last_r;

  entry_t scan_ent;
  entry_t new_ent;
  logic   next_due;
  logic   emit;

  assign scan_ent = entries_r[ptr_r[IDX_W-1:0]];
  assign new_ent  = '{deadline: dd_r, delay: req_delay_r, tag: req_tag_r};
  assign emit     = cmd.do_insert | cmd.do_reject | cmd.do_fire;

  // ties with the head go in front, otherwise after all equal deadlines
  always_comb begin
    stat.req_tick  = (in_req_type == REQ_TICK);
    stat.full      = (occ_r == CNT_W'(QUEUE_DEPTH));
    stat.out_free  = !out_valid_r || out_rsp.ready;
    stat.head_due  = (occ_r != '0) && (entries_r[0].deadline <= now_r) &&
                     (fire_cnt_r < FIRE_W'(MAX_FIRE));
    if (ptr_r == occ_r) begin
      stat.scan_stop = 1'b1;
    end else if (ptr_r == '0) begin
      stat.scan_stop = (dd_r <= scan_ent.deadline);
    end else begin
      stat.scan_stop = (scan_ent.deadline > dd_r);
    end
  end

  assign next_due = (occ_r > CNT_W'(1)) && (entries_r[1].deadline <= now_r) &&
                    ((fire_cnt_r + FIRE_W'(1)) < FIRE_W'(MAX_FIRE));

  // sorted store as a shift line: each cell takes from its lower neighbor on insert, its upper one on fire
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (CNT_W'(i) == ptr_r) begin
          entries_r[i] <= new_ent;
        end else if (CNT_W'(i) > ptr_r) begin
          if (i > 0) begin
            entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (cmd.do_fire) begin
        if (i < QUEUE_DEPTH - 1) begin
          entries_r[i] <= entries_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dd_r        <= now_r + TIME_W'(in_delay);
      req_delay_r <= in_delay;
      req_tag_r   <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      occ_r      <= '0;
      ptr_r      <= '0;
      fire_cnt_r <= '0;
    end else begin
      if (cmd.accept) begin
        ptr_r      <= '0;
        fire_cnt_r <= '0;
        if (in_req_type == REQ_TICK) begin
          now_r <= now_r + TIME_W'(1);
        end
      end
      if (cmd.scan_inc) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
      if (cmd.do_insert) begin
        occ_r <= occ_r + CNT_W'(1);
      end else if (cmd.do_fire) begin
        occ_r      <= occ_r - CNT_W'(1);
        fire_cnt_r <= fire_cnt_r + FIRE_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_fire) begin
      out_kind_r     <= KIND_FIRED;
      out_tag_r      <= entries_r[0].tag;
      out_delay_r    <= entries_r[0].delay;
      out_deadline_r <= entries_r[0].deadline;
      out_last_r     <= !next_due;
    end else if (cmd.do_insert || cmd.do_reject) begin
      out_kind_r     <= cmd.do_insert ? KIND_ACCEPTED : KIND_REJECTED;
      out_tag_r      <= req_tag_r;
      out_delay_r    <= req_delay_r;
      out_deadline_r <= dd_r;
      out_last_r     <= 1'b1;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.kind         = out_kind_r;
  assign out_rsp.out_tag      = out_tag_r;
  assign out_rsp.out_delay    = out_delay_r;
  assign out_rsp.out_deadline = out_deadline_r;
  assign out_rsp.last         = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_rsp.ready))
    else $error("result written over a pending one");

  a_fire_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fire |=> occ_r == $past(occ_r) - CNT_W'(1))
    else $error("fire did not remove head");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> occ_r < CNT_W'(QUEUE_DEPTH))
    else $error("insert into full store");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import doaq_pkg::*;

  // one result as seen on the response channel
  typedef struct {
    kind_t               kind;
    logic [TAG_W-1:0]    tag;
    logic [DELAY_W-1:0]  delay;
    logic [TIME_W-1:0]   deadline;
    logic                last;
  } alarm_result_t;

  // deadlines beyond this distance never come due within the run
  localparam int FAR_AHEAD  = 1000;
  // alarms within this distance get drained by ticking
  localparam int NEAR_AHEAD = 64;

  logic clk = 1'b0;
  logic rst_n;

  doaq_req_if in_req ();
  doaq_rsp_if out_rsp ();

  deadline_ordered_alarm_queue i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  // shadow copy of the sorted alarm store and the seconds counter
  logic [TIME_W-1:0] model_now;
  int                model_count;
  entry_t            model_store [QUEUE_DEPTH];

  // results still owed by the block, oldest first
  alarm_result_t predicted_alarm_results[$];

  int mismatch_count = 0;
  bit sender_gaps_on = 1'b1;
  bit rsp_stalls_on  = 1'b1;
  int rsp_hold       = 0;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // alarms that will never come due during this run
  function automatic int far_count();
    int n;
    n = 0;
    for (int i = 0; i < model_count; i++)
      if (model_store[i].deadline > model_now + FAR_AHEAD) n++;
    return n;
  endfunction

  // alarms close enough to be worth ticking out
  function automatic int near_count();
    int n;
    n = 0;
    for (int i = 0; i < model_count; i++)
      if (model_store[i].deadline <= model_now + NEAR_AHEAD) n++;
    return n;
  endfunction

  // mostly short delays so alarms fire; a few far ones, capped so the store stays usable
  function automatic logic [DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return DELAY_W'($urandom_range(0, 3));
    if (r < 82) return DELAY_W'($urandom_range(4, 15));
    if (r < 96 || far_count() >= 3) return DELAY_W'($urandom_range(16, 60));
    return DELAY_W'($urandom_range(FAR_AHEAD + 1, 65535));
  endfunction

  // apply one accepted request to the shadow store and queue the results it causes
  task automatic advance_alarm_model(input logic rtype, input logic [DELAY_W-1:0] dly,
                                     input logic [TAG_W-1:0] tg);
    logic [TIME_W-1:0] due;
    int                slot;
    int                fired;
    alarm_result_t     res;
    if (rtype == REQ_INSERT) begin
      due          = model_now + TIME_W'(dly);
      res.tag      = tg;
      res.delay    = dly;
      res.deadline = due;
      res.last     = 1'b1;
      if (model_count >= QUEUE_DEPTH) begin
        // full: store untouched, request bounced
        res.kind = KIND_REJECTED;
      end else begin
        // front if no later than the head, else after every entry with deadline <= due
        if (model_count == 0 || due <= model_store[0].deadline) begin
          slot = 0;
        end else begin
          slot = 1;
          while (slot < model_count && model_store[slot].deadline <= due) slot++;
        end
        for (int i = model_count; i > slot; i--) model_store[i] = model_store[i-1];
        model_store[slot] = '{deadline: due, delay: dly, tag: tg};
        model_count++;
        res.kind = KIND_ACCEPTED;
      end
      predicted_alarm_results.push_back(res);
    end else begin
      // tick: advance time, then pop the due alarms at the front, at most MAX_FIRE of them
      model_now = model_now + 1;
      fired     = 0;
      while (fired < model_count && fired < MAX_FIRE &&
             model_store[fired].deadline <= model_now) fired++;
      for (int i = 0; i < fired; i++) begin
        res.kind     = KIND_FIRED;
        res.tag      = model_store[i].tag;
        res.delay    = model_store[i].delay;
        res.deadline = model_store[i].deadline;
        res.last     = (i == fired - 1);
        predicted_alarm_results.push_back(res);
      end
      for (int i = fired; i < model_count; i++) model_store[i-fired] = model_store[i];
      model_count -= fired;
    end
  endtask

  // drive one request at the falling edge, hold it until the handshake
  task automatic send_request(input logic rtype, input logic [DELAY_W-1:0] dly,
                              input logic [TAG_W-1:0] tg);
    int gap;
    gap = pick_gap(sender_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.req_type      = rtype;
    in_req.delay_seconds = dly;
    in_req.tag           = tg;
    in_req.valid         = 1'b1;
    do @(posedge clk); while (!in_req.ready);
    advance_alarm_model(rtype, dly, tg);
  endtask

  // tick with random noise in the unused fields
  task automatic send_tick();
    send_request(REQ_TICK, DELAY_W'($urandom), TAG_W'($urandom));
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic wait_all_results();
    @(negedge clk);
    in_req.valid = 1'b0;
    while (predicted_alarm_results.size() != 0) @(posedge clk);
  endtask

  // tick until no alarm is left within reach
  task automatic drain_due_alarms();
    while (near_count() > 0) send_tick();
  endtask

  // empty tick, sixteen due at once with ties and front inserts, reject when full,
  // field extremes, zero-delay alarms
  task automatic test_directed_edges();
    send_tick();
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(REQ_INSERT, (i % 3 == 0) ? DELAY_W'(0) : DELAY_W'(1), TAG_W'(i * 17));
    send_request(REQ_INSERT, {DELAY_W{1'b1}}, 8'hA5);
    send_tick();
    // max delay, all-ones tag; stays in the store for the rest of the run
    send_request(REQ_INSERT, {DELAY_W{1'b1}}, {TAG_W{1'b1}});
    send_request(REQ_INSERT, 16'd2, 8'h5A);
    send_request(REQ_INSERT, 16'd2, 8'h3C);
    repeat (3) send_tick();
  endtask

  // random mix of inserts and ticks, insert share shifting every few dozen requests
  task automatic test_random_traffic(input int items);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) insert_pct = $urandom_range(25, 70);
      if ($urandom_range(1, 100) <= insert_pct)
        send_request(REQ_INSERT, pick_delay(), TAG_W'($urandom));
      else
        send_tick();
    end
  endtask

  // sender stops until every owed result is in, then resumes with ticks
  task automatic test_pause_for_results();
    repeat (4) send_request(REQ_INSERT, DELAY_W'($urandom_range(0, 3)), TAG_W'($urandom));
    wait_all_results();
    repeat (4) send_tick();
  endtask

  // groups of near-simultaneous alarms, sometimes overfilling the store
  task automatic test_fire_bursts();
    int free_slots;
    int burst;
    for (int g = 0; g < 8; g++) begin
      free_slots = QUEUE_DEPTH - model_count;
      burst      = $urandom_range(1, free_slots + 2);
      repeat (burst)
        send_request(REQ_INSERT, DELAY_W'($urandom_range(0, 2)), TAG_W'($urandom));
      if (g % 3 == 0) wait_all_results();
      repeat (3) send_tick();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    sender_gaps_on = 1'b0;
    rsp_stalls_on  = 1'b0;
    test_random_traffic(80);
    sender_gaps_on = 1'b1;
    rsp_stalls_on  = 1'b1;
  endtask

  // result side backpressure, changed at the falling edge
  always @(negedge clk) begin
    if (!rsp_stalls_on) begin
      out_rsp.ready = 1'b1;
    end else if (rsp_hold > 0) begin
      out_rsp.ready = 1'b0;
      rsp_hold--;
    end else begin
      out_rsp.ready = 1'b1;
      rsp_hold      = pick_gap(1'b1);
    end
  end

  task automatic report_mismatch(input string why, input alarm_result_t want,
                                 input alarm_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: exp kind=%0d tag=%0d delay=%0d deadline=%0d last=%0b, got kind=%0d tag=%0d delay=%0d deadline=%0d last=%0b",
               $realtime, why, want.kind, want.tag, want.delay, want.deadline, want.last,
               got.kind, got.tag, got.delay, got.deadline, got.last);
  endtask

  // compare every accepted result with the oldest prediction
  alarm_result_t seen_result;
  alarm_result_t owed_result;

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      seen_result.kind     = kind_t'(out_rsp.kind);
      seen_result.tag      = out_rsp.out_tag;
      seen_result.delay    = out_rsp.out_delay;
      seen_result.deadline = out_rsp.out_deadline;
      seen_result.last     = out_rsp.last;
      if (predicted_alarm_results.size() == 0) begin
        owed_result = '{KIND_ACCEPTED, '0, '0, '0, 1'b0};
        report_mismatch("result with nothing owed", owed_result, seen_result);
      end else begin
        owed_result = predicted_alarm_results.pop_front();
        if (seen_result.kind !== owed_result.kind || seen_result.tag !== owed_result.tag ||
            seen_result.delay !== owed_result.delay ||
            seen_result.deadline !== owed_result.deadline ||
            seen_result.last !== owed_result.last)
          report_mismatch("result mismatch", owed_result, seen_result);
      end
    end
  end

  // run limit, well above the slowest legal run
  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_req.valid         = 1'b0;
    in_req.req_type      = REQ_TICK;
    in_req.delay_seconds = '0;
    in_req.tag           = '0;
    out_rsp.ready        = 1'b0;
    model_now            = '0;
    model_count          = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_random_traffic(240);
    test_pause_for_results();
    drain_due_alarms();
    test_fire_bursts();
    test_back_to_back();

    // all requests in: wait for the owed results, then let the block settle
    @(negedge clk);
    in_req.valid = 1'b0;
    while (predicted_alarm_results.size() != 0) @(posedge clk);
    repeat (QUEUE_DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0 && predicted_alarm_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/doaq_pkg.sv
design/doaq_if.sv
design/doaq_ctrl.sv
design/doaq_dp.sv
design/deadline_ordered_alarm_queue.sv
tb/tb_top.sv
